// ===== sv/psau_pkg.sv =====
// shared types and constants for the ppu scroll and address unit
package psau_pkg;

  // command codes
  localparam logic [2:0] CMD_CTRL   = 3'd0;
  localparam logic [2:0] CMD_SCROLL = 3'd1;
  localparam logic [2:0] CMD_ADDR   = 3'd2;
  localparam logic [2:0] CMD_STATUS = 3'd3;
  localparam logic [2:0] CMD_DATA   = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;

  // configuration register indexes
  localparam logic CFG_BG_ENABLE = 1'b0;
  localparam logic CFG_MIRROR    = 1'b1;

  // raster geometry
  localparam logic [9:0] DOTS_PER_LINE   = 10'd341;
  localparam logic [9:0] LINES_PER_FRAME = 10'd262;
  localparam logic [8:0] VISIBLE_LINES   = 9'd240;
  localparam logic [8:0] POST_LINE       = 9'd240;
  localparam logic [8:0] VBLANK_LINE     = 9'd241;
  localparam logic [8:0] PRE_LINE        = 9'd261;

  // pointer masks
  localparam logic [15:0] TEMP_NT_KEEP   = 16'hF3FF;
  localparam logic [15:0] SCROLL2_KEEP   = 16'h8C1F;
  localparam logic [15:0] ADDR1_KEEP     = 16'h80FF;
  localparam logic [15:0] HCOPY_KEEP     = 16'hFBE0;
  localparam logic [15:0] HCOPY_TAKE     = 16'h041F;
  localparam logic [15:0] VCOPY_KEEP     = 16'h841F;
  localparam logic [15:0] VCOPY_TAKE     = 16'h7BE0;

  // mirroring masks
  localparam logic [13:0] PAL_MASK       = 14'h3F1F;
  localparam logic [13:0] NT_HIGH_MASK   = 14'h2EFF;
  localparam logic [13:0] NT_TO_2000     = 14'h23FF;
  localparam logic [13:0] NT_TO_2800     = 14'h2BFF;
  localparam logic [13:0] NT_TO_2400     = 14'h27FF;

  typedef struct packed {
    logic [14:0] pointer;
    logic [14:0] temp;
    logic [2:0]  fine_x;
    logic        first_write;
    logic [7:0]  control;
    logic [7:0]  status;
    logic [8:0]  dot;
    logic [8:0]  line;
  } psau_state_t;

  typedef struct packed {
    logic bg_enable;
    logic mirror;
  } psau_cfg_t;

  typedef struct packed {
    logic [13:0] memory_address;
    logic [7:0]  status_byte;
    logic        nmi_request;
    logic [14:0] vram_pointer;
    logic [2:0]  fine_scroll_x;
    logic        frame_done;
  } psau_result_t;

endpackage

// ===== sv/psau_step.sv =====
// next-state and result logic for one command
module psau_step import psau_pkg::*; (
  input  psau_state_t  state_i,
  input  psau_cfg_t    cfg_i,
  input  logic [2:0]   command_i,
  input  logic [7:0]   write_value_i,
  output psau_state_t  state_o,
  output psau_result_t result_o
);

  // fold the pointer into the 14-bit memory space
  function automatic logic [13:0] mirror_addr(logic [14:0] a, logic mode);
    logic [13:0] m;
    logic [13:0] r;
    logic [1:0]  quad;
    m = a[13:0];
    quad = 2'd0;
    if (m < 14'h2000) begin
      r = m;
    end else if (m >= 14'h3F20) begin
      r = m & PAL_MASK;
    end else if (m >= 14'h3F00) begin
      r = m;
    end else begin
      if (m >= 14'h3000) m = m & NT_HIGH_MASK;
      quad = m[11:10];
      r = m;
      if (!mode) begin
        if (quad == 2'd1) r = m & NT_TO_2000;
        else if (quad == 2'd3) r = m & NT_TO_2800;
      end else begin
        if (quad == 2'd2) r = m & NT_TO_2000;
        else if (quad == 2'd3) r = m & NT_TO_2400;
      end
    end
    return r;
  endfunction

  // coarse x increment with horizontal nametable flip
  function automatic logic [14:0] coarse_x_step(logic [14:0] p);
    logic [14:0] r;
    if (p[4:0] == 5'h1F) begin
      r = {p[14:11], ~p[10], p[9:5], 5'h00};
    end else begin
      r = {p[14:5], p[4:0] + 5'd1};
    end
    return r;
  endfunction

  // fine and coarse y increment
  function automatic logic [14:0] y_step(logic [14:0] p);
    logic [14:0] r;
    logic [4:0]  y;
    if (p[14:12] != 3'd7) begin
      r = {p[14:12] + 3'd1, p[11:0]};
    end else begin
      y = p[9:5];
      r = {3'd0, p[11:0]};
      if (y == 5'd29) begin
        y = 5'd0;
        r[11] = ~r[11];
      end else if (y == 5'd31) begin
        y = 5'd0;
      end else begin
        y = y + 5'd1;
      end
      r[9:5] = y;
    end
    return r;
  endfunction

  logic [9:0]  dot_inc;
  logic [9:0]  line_inc;
  logic        pre_line;
  logic        scroll_on;
  logic        coarse_dot;
  logic [13:0] mirrored;
  logic [14:0] scroll_temp;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    dot_inc  = {1'b0, state_i.dot} + 10'd1;
    line_inc = {1'b0, state_i.line} + 10'd1;
    pre_line = (state_i.line == PRE_LINE);
    scroll_on = cfg_i.bg_enable && (state_i.line < VISIBLE_LINES || pre_line);
    coarse_dot = (state_i.dot[2:0] == 3'd0) && (state_i.dot != 9'd0) &&
                 (state_i.dot < 9'd256 || (state_i.dot > 9'd327 && state_i.dot < 9'd337));
    mirrored = mirror_addr(state_i.pointer, cfg_i.mirror);
    scroll_temp = (state_i.temp & SCROLL2_KEEP[14:0]) | {write_value_i[2:0], 12'd0} |
                  {5'd0, write_value_i[7:3], 5'd0};

    case (command_i)
      CMD_CTRL: begin
        state_o.control = write_value_i;
        state_o.temp = (state_i.temp & TEMP_NT_KEEP[14:0]) | {3'd0, write_value_i[1:0], 10'd0};
      end
      CMD_SCROLL: begin
        if (state_i.first_write) begin
          state_o.temp = {state_i.temp[14:5], write_value_i[7:3]};
          state_o.fine_x = write_value_i[2:0];
          state_o.first_write = 1'b0;
        end else begin
          state_o.temp = scroll_temp;
          state_o.first_write = 1'b1;
        end
      end
      CMD_ADDR: begin
        if (state_i.first_write) begin
          state_o.temp = (state_i.temp & ADDR1_KEEP[14:0]) | {1'b0, write_value_i[5:0], 8'd0};
          state_o.first_write = 1'b0;
        end else begin
          state_o.temp = {state_i.temp[14:8], write_value_i};
          state_o.pointer = {state_i.temp[14:8], write_value_i};
          state_o.first_write = 1'b1;
        end
      end
      CMD_STATUS: begin
        result_o.status_byte = state_i.status;
        state_o.status = {1'b0, state_i.status[6:0]};
        state_o.first_write = 1'b1;
      end
      CMD_DATA: begin
        result_o.memory_address = mirrored;
        state_o.pointer = {1'b0, mirrored} + (state_i.control[2] ? 15'd32 : 15'd1);
      end
      CMD_TICK: begin
        // background scroll work on render and pre-render lines
        if (scroll_on) begin
          if (coarse_dot) begin
            state_o.pointer = coarse_x_step(state_i.pointer);
          end else if (state_i.dot == 9'd256) begin
            state_o.pointer = y_step(state_i.pointer);
          end else if (state_i.dot == 9'd257) begin
            state_o.pointer = (state_i.pointer & HCOPY_KEEP[14:0]) |
                              (state_i.temp & HCOPY_TAKE[14:0]);
          end else if (pre_line && state_i.dot >= 9'd280 && state_i.dot <= 9'd304) begin
            state_o.pointer = (state_i.pointer & VCOPY_KEEP[14:0]) |
                              (state_i.temp & VCOPY_TAKE[14:0]);
          end
        end
        // frame and vblank events
        if (state_i.line == POST_LINE) begin
          result_o.frame_done = (state_i.dot == 9'd0) && cfg_i.bg_enable;
        end else if (pre_line) begin
          if (state_i.dot == 9'd1) state_o.status = {3'd0, state_i.status[4:0]};
        end else if (state_i.line >= VISIBLE_LINES && state_i.dot == 9'd1 &&
                     state_i.line == VBLANK_LINE) begin
          state_o.status = {1'b1, state_i.status[6:0]};
          result_o.nmi_request = state_i.control[7];
        end
        // raster counter
        if (dot_inc >= DOTS_PER_LINE) begin
          state_o.dot = 9'd0;
          state_o.line = (line_inc >= LINES_PER_FRAME) ? 9'd0 : line_inc[8:0];
        end else begin
          state_o.dot = dot_inc[8:0];
        end
      end
      default: begin
      end
    endcase

    result_o.vram_pointer  = state_o.pointer;
    result_o.fine_scroll_x = state_o.fine_x;
  end

endmodule

// ===== sv/ppu_scroll_address_unit_core.sv =====
// top level of the ppu scroll and address unit
// The unit takes one command per clock: register writes, status reads, data
// accesses and dot ticks are all computed combinationally. The register state
// is updated at the transfer and the result is registered in the output
// register, or in the skid register while the output is held. A two-entry
// output buffer (output register plus skid register) lets commands keep
// flowing while a result waits; the input stalls only once both entries
// are full. Configuration writes take effect at the next clock edge.
module ppu_scroll_address_unit_core import psau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [7:0]  write_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] memory_address_o,
  output logic [7:0]  status_byte_o,
  output logic        nmi_request_o,
  output logic [14:0] vram_pointer_o,
  output logic [2:0]  fine_scroll_x_o,
  output logic        frame_done_o
);

  psau_cfg_t    cfg_q;
  psau_state_t  st_q, st_d;
  psau_result_t res_d;
  psau_result_t out_q;
  psau_result_t skid_q;
  logic         out_valid_q;
  logic         skid_valid_q;
  logic         in_xfer;
  logic         out_free;

  assign in_stall_o = skid_valid_q;
  assign in_xfer    = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BG_ENABLE: cfg_q.bg_enable <= cfg_wdata_i;
        CFG_MIRROR:    cfg_q.mirror <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  psau_step u_step (
    .state_i       (st_q),
    .cfg_i         (cfg_q),
    .command_i     (command_i),
    .write_value_i (write_value_i),
    .state_o       (st_d),
    .result_o      (res_d)
  );

  // register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{pointer: '0, temp: '0, fine_x: '0, first_write: 1'b1,
                control: '0, status: '0, dot: '0, line: '0};
    end else if (in_xfer) begin
      st_q <= st_d;
    end
  end

  // output buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q  <= in_xfer || skid_valid_q;
        skid_valid_q <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // output buffer payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (in_xfer) begin
      skid_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign memory_address_o = out_q.memory_address;
  assign status_byte_o    = out_q.status_byte;
  assign nmi_request_o    = out_q.nmi_request;
  assign vram_pointer_o   = out_q.vram_pointer;
  assign fine_scroll_x_o  = out_q.fine_scroll_x;
  assign frame_done_o     = out_q.frame_done;

  // skid entry is only used behind a held output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid without output entry");

  // dot counter stays inside the line
  a_dot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.dot < DOTS_PER_LINE[8:0])
    else $error("dot counter out of range");

  // an nmi request leaves vblank set
  a_nmi_sets_vblank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && res_d.nmi_request) |=> st_q.status[7])
    else $error("nmi request without vblank");

  // frame done only with background on
  a_frame_done_bg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && res_d.frame_done) |-> (cfg_q.bg_enable && command_i == CMD_TICK))
    else $error("frame done without background tick");

endmodule

// ===== tb/tb.sv =====
// testbench for the ppu scroll and address unit: directed and random command traffic checked against a predictor
`timescale 1ns / 1ps

module tb;
  import psau_pkg::*;

  // command codes the block leaves unused
  localparam logic [2:0] CMD_UNUSED_A = 3'd6;
  localparam logic [2:0] CMD_UNUSED_B = 3'd7;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] val;
  } ppu_cmd_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic        cfg_wdata_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  command_i = '0;
  logic [7:0]  write_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [13:0] memory_address_o;
  logic [7:0]  status_byte_o;
  logic        nmi_request_o;
  logic [14:0] vram_pointer_o;
  logic [2:0]  fine_scroll_x_o;
  logic        frame_done_o;

  // commands waiting to be sent and results waiting to come back
  ppu_cmd_t     ppu_cmds_q[$];
  psau_result_t ppu_results_q[$];

  // shadow copy of the unit state and its configuration
  psau_state_t raster_st;
  psau_cfg_t   unit_cfg;

  ppu_cmd_t     next_cmd;
  psau_result_t want;
  psau_result_t got;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int send_gap = 0;
  int stall_left = 0;

  int checked_results = 0;
  int mismatch_count = 0;
  int nmi_seen = 0;
  int frame_seen = 0;
  int vblank_reads = 0;

  ppu_scroll_address_unit_core uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .command_i        (command_i),
    .write_value_i    (write_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .memory_address_o (memory_address_o),
    .status_byte_o    (status_byte_o),
    .nmi_request_o    (nmi_request_o),
    .vram_pointer_o   (vram_pointer_o),
    .fine_scroll_x_o  (fine_scroll_x_o),
    .frame_done_o     (frame_done_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // fold a pointer into the 14-bit memory space
  function automatic logic [13:0] mirror_vram(input logic [14:0] p, input logic vertical);
    logic [13:0] a;
    logic [1:0]  quad;
    a = p[13:0];
    if (a < 14'h2000) return a;
    if (a >= 14'h3F20) return a & PAL_MASK;
    if (a >= 14'h3F00) return a;
    if (a >= 14'h3000) a = a & NT_HIGH_MASK;
    quad = a[11:10];
    if (!vertical) begin
      if (quad == 2'd1) return a & NT_TO_2000;
      if (quad == 2'd3) return a & NT_TO_2800;
      return a;
    end
    if (quad == 2'd2) return a & NT_TO_2000;
    if (quad == 2'd3) return a & NT_TO_2400;
    return a;
  endfunction

  // pointer update done by one rendering dot
  function automatic logic [14:0] scroll_pointer(input logic [14:0] p, input logic [14:0] t,
                                                 input logic [8:0] d, input logic pre);
    logic [4:0] y;
    if (d[2:0] == 3'd0 && d != 9'd0 && (d < 9'd256 || (d > 9'd327 && d < 9'd337))) begin
      // coarse x, wrapping into the neighbor nametable
      if (p[4:0] == 5'h1F) begin
        p[4:0] = 5'h00;
        p[10] = ~p[10];
      end else begin
        p = p + 15'd1;
      end
    end else if (d == 9'd256) begin
      // fine y, then coarse y with the row 29 nametable flip
      if (p[14:12] != 3'b111) begin
        p[14:12] = p[14:12] + 3'd1;
      end else begin
        p[14:12] = 3'd0;
        y = p[9:5];
        if (y == 5'd29) begin
          y = 5'd0;
          p[11] = ~p[11];
        end else if (y == 5'd31) begin
          y = 5'd0;
        end else begin
          y = y + 5'd1;
        end
        p[9:5] = y;
      end
    end else if (d == 9'd257) begin
      p = (p & HCOPY_KEEP[14:0]) | (t & HCOPY_TAKE[14:0]);
    end else if (pre && d >= 9'd280 && d <= 9'd304) begin
      p = (p & VCOPY_KEEP[14:0]) | (t & VCOPY_TAKE[14:0]);
    end
    return p;
  endfunction

  // apply one command to the shadow state and return the result it produces
  function automatic psau_result_t step_scroll_unit(input logic [2:0] cmd, input logic [7:0] val);
    psau_result_t r;
    logic [13:0]  mem;
    r = '0;
    case (cmd)
      CMD_CTRL: begin
        raster_st.control = val;
        raster_st.temp[11:10] = val[1:0];
      end
      CMD_SCROLL: begin
        if (raster_st.first_write) begin
          raster_st.temp[4:0] = val[7:3];
          raster_st.fine_x = val[2:0];
          raster_st.first_write = 1'b0;
        end else begin
          raster_st.temp[14:12] = val[2:0];
          raster_st.temp[9:5] = val[7:3];
          raster_st.first_write = 1'b1;
        end
      end
      CMD_ADDR: begin
        if (raster_st.first_write) begin
          raster_st.temp[14] = 1'b0;
          raster_st.temp[13:8] = val[5:0];
          raster_st.first_write = 1'b0;
        end else begin
          raster_st.temp[7:0] = val;
          raster_st.first_write = 1'b1;
          raster_st.pointer = raster_st.temp;
        end
      end
      CMD_STATUS: begin
        r.status_byte = raster_st.status;
        raster_st.status[7] = 1'b0;
        raster_st.first_write = 1'b1;
      end
      CMD_DATA: begin
        mem = mirror_vram(raster_st.pointer, unit_cfg.mirror);
        r.memory_address = mem;
        raster_st.pointer = {1'b0, mem} + (raster_st.control[2] ? 15'd32 : 15'd1);
      end
      CMD_TICK: begin
        if (raster_st.line < VISIBLE_LINES) begin
          if (unit_cfg.bg_enable)
            raster_st.pointer = scroll_pointer(raster_st.pointer, raster_st.temp,
                                               raster_st.dot, 1'b0);
        end else if (raster_st.line == POST_LINE) begin
          if (raster_st.dot == 9'd0 && unit_cfg.bg_enable) r.frame_done = 1'b1;
        end else if (raster_st.line == PRE_LINE) begin
          if (raster_st.dot == 9'd1) raster_st.status[7:5] = 3'b000;
          if (unit_cfg.bg_enable)
            raster_st.pointer = scroll_pointer(raster_st.pointer, raster_st.temp,
                                               raster_st.dot, 1'b1);
        end else if (raster_st.dot == 9'd1 && raster_st.line == VBLANK_LINE) begin
          raster_st.status[7] = 1'b1;
          r.nmi_request = raster_st.control[7];
        end
        // raster counter wraps at the end of each line and frame
        if ({1'b0, raster_st.dot} + 10'd1 >= DOTS_PER_LINE) begin
          raster_st.dot = 9'd0;
          if ({1'b0, raster_st.line} + 10'd1 >= LINES_PER_FRAME) raster_st.line = 9'd0;
          else raster_st.line = raster_st.line + 9'd1;
        end else begin
          raster_st.dot = raster_st.dot + 9'd1;
        end
      end
      default: begin
      end
    endcase
    r.vram_pointer = raster_st.pointer;
    r.fine_scroll_x = raster_st.fine_x;
    return r;
  endfunction

  // command driver: predict on each transfer, then present the next command
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        ppu_results_q.push_back(step_scroll_unit(command_i, write_value_i));
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0 && send_idle_pct != 0) begin
          send_gap = send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
          send_gap = $urandom_range(1, 18) - 1;
          in_valid_i <= 1'b0;
        end else if (ppu_cmds_q.size() > 0) begin
          next_cmd = ppu_cmds_q.pop_front();
          command_i <= next_cmd.cmd;
          write_value_i <= next_cmd.val;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each transfer with the oldest prediction, stall in bursts
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{memory_address: memory_address_o, status_byte: status_byte_o,
                nmi_request: nmi_request_o, vram_pointer: vram_pointer_o,
                fine_scroll_x: fine_scroll_x_o, frame_done: frame_done_o};
        if (got.nmi_request) nmi_seen = nmi_seen + 1;
        if (got.frame_done) frame_seen = frame_seen + 1;
        if (got.status_byte[7]) vblank_reads = vblank_reads + 1;
        if (ppu_results_q.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("result with no command pending: ptr=%h", got.vram_pointer);
        end else begin
          want = ppu_results_q.pop_front();
          if (got.memory_address !== want.memory_address ||
              got.status_byte !== want.status_byte ||
              got.nmi_request !== want.nmi_request ||
              got.vram_pointer !== want.vram_pointer ||
              got.fine_scroll_x !== want.fine_scroll_x ||
              got.frame_done !== want.frame_done) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("result %0d: want mem=%h stat=%h nmi=%b ptr=%h fx=%0d done=%b",
                       checked_results, want.memory_address, want.status_byte,
                       want.nmi_request, want.vram_pointer, want.fine_scroll_x,
                       want.frame_done,
                       "  got mem=%h stat=%h nmi=%b ptr=%h fx=%0d done=%b",
                       got.memory_address, got.status_byte, got.nmi_request,
                       got.vram_pointer, got.fine_scroll_x, got.frame_done);
          end
        end
        checked_results = checked_results + 1;
      end
      if (stall_left > 0 && recv_idle_pct != 0) begin
        stall_left = stall_left - 1;
        out_stall_i <= 1'b1;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(1, 18) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic push_cmd(input logic [2:0] cmd, input logic [7:0] val);
    ppu_cmds_q.push_back('{cmd: cmd, val: val});
  endtask

  // one register write while the unit is idle
  task automatic set_cfg(input logic idx, input logic val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BG_ENABLE) unit_cfg.bg_enable = val;
    else unit_cfg.mirror = val;
  endtask

  // wait until every queued command has been sent and answered
  task automatic wait_idle();
    @(negedge clk_i);
    while (ppu_cmds_q.size() != 0 || in_valid_i || ppu_results_q.size() != 0)
      @(negedge clk_i);
  endtask

  // one short sequence the way software drives the chip, plus some noise
  task automatic push_sequence(input logic keep_nmi);
    int          pick;
    int          n;
    logic [7:0]  v;
    logic [2:0]  c;
    pick = $urandom_range(0, 99);
    v = 8'($urandom_range(0, 255));
    if (pick < 25) begin
      push_cmd(CMD_ADDR, v);
      push_cmd(CMD_ADDR, 8'($urandom_range(0, 255)));
      n = $urandom_range(1, 4);
      repeat (n) push_cmd(CMD_DATA, 8'($urandom_range(0, 255)));
    end else if (pick < 40) begin
      push_cmd(CMD_SCROLL, v);
      push_cmd(CMD_SCROLL, 8'($urandom_range(0, 255)));
    end else if (pick < 48) begin
      if (keep_nmi) v[7] = 1'b1;
      push_cmd(CMD_CTRL, v);
    end else if (pick < 56) begin
      push_cmd(CMD_STATUS, v);
    end else if (pick < 78) begin
      n = $urandom_range(1, 40);
      repeat (n) push_cmd(CMD_TICK, 8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      // lone command of any code, breaks write pairs
      c = 3'($urandom_range(0, 7));
      if (keep_nmi && c == CMD_CTRL) v[7] = 1'b1;
      push_cmd(c, v);
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) push_cmd(CMD_DATA, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic queue_random(input int n);
    while (ppu_cmds_q.size() < n) push_sequence(1'b0);
  endtask

  // a short run of dots with occasional register traffic
  task automatic queue_frame(input logic keep_nmi);
    int ticks;
    ticks = 0;
    while (ticks < 60) begin
      if ($urandom_range(0, 299) == 0) begin
        push_sequence(keep_nmi);
      end else begin
        push_cmd(CMD_TICK, 8'($urandom_range(0, 255)));
        ticks = ticks + 1;
      end
    end
  endtask

  // stimulus phases
  initial begin
    raster_st = '0;
    raster_st.first_write = 1'b1;
    unit_cfg = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: address folding, pointer steps, toggle reset, unused codes
    set_cfg(CFG_BG_ENABLE, 1'b1);
    set_cfg(CFG_MIRROR, 1'b0);
    send_idle_pct = 8;
    recv_idle_pct = 8;
    push_cmd(CMD_CTRL, 8'h03);
    push_cmd(CMD_SCROLL, 8'hFF);
    push_cmd(CMD_SCROLL, 8'h00);
    push_cmd(CMD_ADDR, 8'hFF);
    push_cmd(CMD_ADDR, 8'h1F);
    push_cmd(CMD_DATA, 8'h00);
    push_cmd(CMD_DATA, 8'hFF);
    push_cmd(CMD_ADDR, 8'h30);
    push_cmd(CMD_ADDR, 8'h00);
    push_cmd(CMD_DATA, 8'h00);
    push_cmd(CMD_ADDR, 8'h2C);
    push_cmd(CMD_ADDR, 8'h05);
    push_cmd(CMD_DATA, 8'h00);
    push_cmd(CMD_CTRL, 8'h84);
    push_cmd(CMD_ADDR, 8'h24);
    push_cmd(CMD_ADDR, 8'hE0);
    push_cmd(CMD_DATA, 8'h00);
    push_cmd(CMD_DATA, 8'h00);
    push_cmd(CMD_ADDR, 8'h00);
    push_cmd(CMD_STATUS, 8'hFF);
    push_cmd(CMD_ADDR, 8'h3E);
    push_cmd(CMD_ADDR, 8'hFF);
    push_cmd(CMD_DATA, 8'h00);
    push_cmd(CMD_UNUSED_A, 8'hAA);
    push_cmd(CMD_UNUSED_B, 8'h55);
    push_cmd(CMD_TICK, 8'h00);
    wait_idle();

    // random traffic, horizontal mirroring, background on
    send_idle_pct = 6;
    recv_idle_pct = 6;
    queue_random(500);
    wait_idle();

    // dot run with nmi enabled, vertical mirroring
    set_cfg(CFG_MIRROR, 1'b1);
    send_idle_pct = 1;
    recv_idle_pct = 1;
    push_cmd(CMD_CTRL, 8'h80 | 8'($urandom_range(0, 127)));
    queue_frame(1'b1);
    wait_idle();

    // random traffic with background off, receiver heavy stalls
    set_cfg(CFG_BG_ENABLE, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 15;
    queue_random(500);
    wait_idle();

    // dot run with background off and free control writes
    set_cfg(CFG_MIRROR, 1'b0);
    send_idle_pct = 1;
    recv_idle_pct = 1;
    queue_frame(1'b0);
    wait_idle();

    // random traffic, sender heavy gaps
    set_cfg(CFG_BG_ENABLE, 1'b1);
    set_cfg(CFG_MIRROR, 1'b1);
    send_idle_pct = 15;
    recv_idle_pct = 0;
    queue_random(500);
    wait_idle();

    // closing stretch at full rate
    set_cfg(CFG_MIRROR, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(250);
    wait_idle();
    repeat (20) @(posedge clk_i);

    $display("checked %0d results over short dot runs and mixed register traffic",
             checked_results);
    $display("nmi pulses %0d, frame ends %0d, vblank status reads %0d, mismatches %0d",
             nmi_seen, frame_seen, vblank_reads, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
